// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the moving average clamp filter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that whenever a holds, b holds in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// Check that whenever a holds, b holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`else

`define ASSERT_SAME(label, clk, rst_n, a, b, msg)
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg)

`endif

`endif

// File: src/macf_pkg.sv
// ----------------------------------------------------------------------------
// macf_pkg
// Types and constants shared by the moving average clamp filter.
// ----------------------------------------------------------------------------
package macf_pkg;

    localparam int WINDOW_LOG2 = 4;
    localparam int WINDOW_LEN  = 1 << WINDOW_LOG2;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = SAMPLE_W + WINDOW_LOG2;
    localparam int LIMIT_W  = 13;
    localparam int INDEX_W  = 2;

    // x / 10 == (x * 52429) >> 19 for every 16-bit unsigned x
    localparam int                  DIV10_SHIFT = 19;
    localparam logic [SAMPLE_W-1:0] DIV10_MUL   = 16'd52429;

    // Configuration register indexes
    localparam logic [INDEX_W-1:0] REG_LIMIT_MIN = 2'd0;
    localparam logic [INDEX_W-1:0] REG_LIMIT_MAX = 2'd1;

    localparam logic signed [LIMIT_W-1:0] LIMIT_MIN_RESET = -13'sd3277;
    localparam logic signed [LIMIT_W-1:0] LIMIT_MAX_RESET = 13'sd3276;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic signed [LIMIT_W-1:0]  t_limit;
    typedef logic [WINDOW_LOG2-1:0]     t_ptr;
    typedef logic [INDEX_W-1:0]         t_index;

    // Value headed for the divider, with its warm-up status
    typedef struct packed {
        t_sample value;
        logic    settled;
    } t_window_item;

    // Quotient headed for the clamp
    typedef struct packed {
        t_limit quot;
        logic   settled;
    } t_div_item;

endpackage

// File: src/macf_ifs.sv
// ----------------------------------------------------------------------------
// macf channel interfaces
// Valid/ready channels for samples, results and configuration writes.
// ----------------------------------------------------------------------------
interface macf_sample_if;
    import macf_pkg::*;
    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface macf_result_if;
    import macf_pkg::*;
    logic   valid;
    logic   ready;
    t_limit average;
    logic   settled;

    modport source (output valid, output average, output settled, input ready);
    modport sink   (input valid, input average, input settled, output ready);
endinterface

interface macf_cfg_if;
    import macf_pkg::*;
    logic   valid;
    logic   ready;
    t_index index;
    t_limit data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/macf_window.sv
// ----------------------------------------------------------------------------
// macf_window
// Sample ring, running sum and warm-up tracking; first pipeline stage.
// ----------------------------------------------------------------------------
module macf_window (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  macf_pkg::t_sample      i_sample,
    output logic                   o_valid,
    output macf_pkg::t_window_item o_item,
    output logic                   o_full
);
    import macf_pkg::*;

    t_sample      r_store [WINDOW_LEN];
    t_ptr         r_ptr;
    logic         r_full;
    t_sum         r_sum;
    logic         r_valid;
    t_window_item r_item;

    logic    w_fire;
    t_sample w_old;
    t_sum    n_sum;
    t_sum    w_shifted;

    assign w_fire = i_en && i_valid;

    // Entries not yet written are only ever read during warm-up: read zero then
    assign w_old     = r_full ? r_store[r_ptr] : '0;
    assign n_sum     = r_sum - SUM_W'(w_old) + SUM_W'(i_sample);
    assign w_shifted = n_sum >>> WINDOW_LOG2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_full  <= 1'b0;
            r_sum   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_en) begin
                r_valid <= i_valid;
            end
            if (w_fire) begin
                r_ptr <= r_ptr + 1'b1;
                r_sum <= n_sum;
                if (r_ptr == t_ptr'(WINDOW_LEN - 1)) begin
                    r_full <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_store[r_ptr] <= i_sample;
            r_item.settled <= r_full;
            r_item.value   <= r_full ? t_sample'(w_shifted) : i_sample;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_full  = r_full;

endmodule

// File: src/macf_div10.sv
// ----------------------------------------------------------------------------
// macf_div10
// Signed divide by ten, truncating toward zero; second pipeline stage.
// ----------------------------------------------------------------------------
module macf_div10 (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  macf_pkg::t_window_item i_item,
    output logic                   o_valid,
    output macf_pkg::t_div_item    o_item
);
    import macf_pkg::*;

    logic                      r_valid;
    t_div_item                 r_item;
    logic [SAMPLE_W-1:0]       w_mag;
    logic [2*SAMPLE_W-1:0]     w_prod;
    t_limit                    w_quot;

    // Divide the magnitude, then restore the sign
    assign w_mag  = i_item.value[SAMPLE_W-1] ? SAMPLE_W'(-i_item.value)
                                             : SAMPLE_W'(i_item.value);
    assign w_prod = (2*SAMPLE_W)'(w_mag) * (2*SAMPLE_W)'(DIV10_MUL);
    assign w_quot = t_limit'(w_prod[DIV10_SHIFT +: LIMIT_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_item.quot    <= i_item.value[SAMPLE_W-1] ? -w_quot : w_quot;
            r_item.settled <= i_item.settled;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: src/moving_average_clamp_filter.sv
// ----------------------------------------------------------------------------
// moving_average_clamp_filter
// Boxcar moving average of temperature samples, scaled and clamped.
// ----------------------------------------------------------------------------
// Takes one signed sample (tenths of a degree) per transfer and returns one
// result per sample, in order, in whole degrees. The first 16 samples fill the
// window and are passed through divided by ten with settled low; from the 17th
// sample on, the result is the floor of the window mean divided by ten
// (toward zero) with settled high. Every result is raised to limit_min, then
// lowered to limit_max (register 0 and 1 of the configuration channel; only
// write them while no sample is in flight). The block sustains one sample per
// clock while the output does not stall: a running sum replaces the window
// loop, so each sample needs one read and one write of the ring. Three
// register stages sit between input and output: ring/sum stage, divide-by-ten
// multiplier stage, clamp/output register. A stalled output backs up the
// stages; input ready stays high whenever any stage has room.
// ----------------------------------------------------------------------------
module moving_average_clamp_filter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    macf_sample_if.sink          i_sample,
    macf_result_if.source        o_result,
    macf_cfg_if.sink             i_cfg
);
    import macf_pkg::*;

    `include "assert_macros.svh"

    t_limit       r_limit_min;
    t_limit       r_limit_max;

    logic         w_en1;
    logic         w_en2;
    logic         w_en3;

    logic         w_v1;
    t_window_item w_item1;
    logic         w_full;
    logic         w_v2;
    t_div_item    w_item2;

    logic         r_out_valid;
    t_limit       r_average;
    logic         r_settled;
    t_limit       w_raised;
    t_limit       w_clamped;

    // ------------------------------------------------------------------
    // Configuration: always ready, ignore unknown indexes
    // ------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_min <= LIMIT_MIN_RESET;
            r_limit_max <= LIMIT_MAX_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_LIMIT_MIN: r_limit_min <= i_cfg.data;
                REG_LIMIT_MAX: r_limit_max <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: a stage loads when it is empty or its contents move on
    // ------------------------------------------------------------------
    assign w_en3 = !r_out_valid || o_result.ready;
    assign w_en2 = !w_v2 || w_en3;
    assign w_en1 = !w_v1 || w_en2;

    assign i_sample.ready = w_en1;

    // Stage 1: ring write, running sum, mean or pass-through
    macf_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en1),
        .i_valid  (i_sample.valid),
        .i_sample (i_sample.sample),
        .o_valid  (w_v1),
        .o_item   (w_item1),
        .o_full   (w_full)
    );

    // Stage 2: divide by ten
    macf_div10 u_div10 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en2),
        .i_valid (w_v1),
        .i_item  (w_item1),
        .o_valid (w_v2),
        .o_item  (w_item2)
    );

    // ------------------------------------------------------------------
    // Stage 3: clamp, lower limit first so crossed limits give limit_max
    // ------------------------------------------------------------------
    assign w_raised  = (w_item2.quot < r_limit_min) ? r_limit_min : w_item2.quot;
    assign w_clamped = (w_raised > r_limit_max) ? r_limit_max : w_raised;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en3) begin
            r_out_valid <= w_v2;
        end
    end

    // Hold the result while the sink stalls
    always_ff @(posedge i_clk) begin
        if (w_en3 && w_v2) begin
            r_average <= w_clamped;
            r_settled <= w_item2.settled;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.average = r_average;
    assign o_result.settled = r_settled;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_SAME(a_settled_needs_full, i_clk, i_rst_n, r_out_valid && r_settled, w_full, "settled result before the window filled")
    `ASSERT_SAME(a_result_in_limits, i_clk, i_rst_n, r_out_valid && (r_limit_min <= r_limit_max), (r_average >= r_limit_min) && (r_average <= r_limit_max), "result outside configured limits")
    `ASSERT_NEXT(a_transfer_loads_stage1, i_clk, i_rst_n, i_sample.valid && i_sample.ready, w_v1, "accepted sample missing from first stage")

endmodule
